FILE: src/aabb_pkg.sv
// ----------------------------------------------------------------------------
// aabb_pkg
// Shared types, sizes and helper functions of the pairwise box collision scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aabb_pkg;

  localparam int MAX_BOXES = 32;
  localparam int TAG_KINDS = 8;
  localparam int IDX_W     = $clog2(MAX_BOXES);
  localparam int CNT_W     = $clog2(MAX_BOXES + 1);
  localparam int TAG_W     = 3;
  localparam int MASK_W    = 64;
  localparam int EDGE_W    = 17;

  typedef struct packed {
    logic              frame_start;
    logic signed [15:0] box_x;
    logic signed [15:0] box_y;
    logic [14:0]       box_w;
    logic [14:0]       box_h;
    logic [TAG_W-1:0]  box_tag;
  } item_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] earlier_index;
    logic [CNT_W-1:0] new_index;
    logic             last_pair;
  } result_word_t;

  typedef struct packed {
    logic signed [15:0] y;
    logic signed [15:0] x;
    logic [14:0]        h;
    logic [14:0]        w;
    logic [TAG_W-1:0]   tag;
  } box_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    box_t             data;
  } ram_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } ram_rd_t;

  // Strict overlap test; edges that only touch do not count.
  function automatic logic box_overlap(box_t a, box_t b);
    logic [EDGE_W-1:0] a_top;
    logic [EDGE_W-1:0] a_bot;
    logic [EDGE_W-1:0] a_lft;
    logic [EDGE_W-1:0] a_rgt;
    logic [EDGE_W-1:0] b_top;
    logic [EDGE_W-1:0] b_bot;
    logic [EDGE_W-1:0] b_lft;
    logic [EDGE_W-1:0] b_rgt;
    a_top = {a.y[15], a.y};
    a_lft = {a.x[15], a.x};
    a_bot = a_top + {2'b00, a.h};
    a_rgt = a_lft + {2'b00, a.w};
    b_top = {b.y[15], b.y};
    b_lft = {b.x[15], b.x};
    b_bot = b_top + {2'b00, b.h};
    b_rgt = b_lft + {2'b00, b.w};
    return ($signed(a_bot) > $signed(b_top)) && ($signed(a_top) < $signed(b_bot)) &&
           ($signed(a_rgt) > $signed(b_lft)) && ($signed(a_lft) < $signed(b_rgt));
  endfunction

  // A tag pair matches if either ordering is set in the mask.
  function automatic logic tag_match(logic [MASK_W-1:0] mask, logic [TAG_W-1:0] ta,
                                     logic [TAG_W-1:0] tb);
    logic [2*TAG_W-1:0] i_ab;
    logic [2*TAG_W-1:0] i_ba;
    logic               in_range;
    i_ab     = {ta, tb};
    i_ba     = {tb, ta};
    in_range = (int'(ta) < TAG_KINDS) && (int'(tb) < TAG_KINDS);
    return in_range && (mask[i_ab] || mask[i_ba]);
  endfunction

endpackage

`default_nettype wire

FILE: src/aabb_pair_collision_scan.sv
// A new box is taken only in the idle state, once the scan of the previous box is done.
// The scan reads one stored box per cycle through the single read port of the box memory,
// except while a found pair waits on a stalled result output.
// Reset clears the stored-box count, the subscription mask and all valid flags.
// The box memory itself is not cleared; only slots below the count are ever read.
// ----------------------------------------------------------------------------
// aabb_pair_collision_scan
// Pairwise strict-overlap scan of tagged boxes with a tag subscription mask.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aabb_pair_collision_scan
  import aabb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [MASK_W-1:0] cfg_wdata,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire item_word_t        item,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output result_word_t           result
);

  logic [MASK_W-1:0] subscribe_mask;
  ram_wr_t           ram_wr;
  ram_rd_t           ram_rd;
  box_t              ram_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      subscribe_mask <= '0;
    end else if (cfg_we) begin
      subscribe_mask <= cfg_wdata;
    end
  end

  aabb_scan u_scan (
    .clk          (clk),
    .rst          (rst),
    .mask         (subscribe_mask),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .ram_wr       (ram_wr),
    .ram_rd       (ram_rd),
    .ram_q        (ram_q)
  );

  aabb_box_ram u_ram (
    .clk   (clk),
    .wr    (ram_wr),
    .rd    (ram_rd),
    .rdata (ram_q)
  );

endmodule

`default_nettype wire

FILE: src/aabb_box_ram.sv
// ----------------------------------------------------------------------------
// aabb_box_ram
// Box store of the current frame: one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aabb_box_ram
  import aabb_pkg::*;
(
  input  wire logic    clk,
  input  wire ram_wr_t wr,
  input  wire ram_rd_t rd,
  output box_t         rdata
);

  box_t mem [MAX_BOXES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rdata <= mem[rd.addr];
    end
  end

endmodule

`default_nettype wire

FILE: src/aabb_scan.sv
// ----------------------------------------------------------------------------
// aabb_scan
// Sequencer that scans the stored boxes against a new box and emits pairs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aabb_scan
  import aabb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [MASK_W-1:0] mask,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire item_word_t        item,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output result_word_t           result,
  output ram_wr_t                ram_wr,
  output ram_rd_t                ram_rd,
  input  wire box_t              ram_q
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]       state;
  box_t             cur;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] rd_idx;
  logic             cmp_valid;
  logic [IDX_W-1:0] cmp_idx;
  logic [IDX_W-1:0] hit_cnt;
  logic             pend_valid;
  logic [IDX_W-1:0] pend_idx;

  logic raw_hit;
  logic take_hit;
  logic out_free;
  logic adv;
  logic issue;
  logic flush_go;
  logic not_full;
  logic emit;

  assign item_ready = (state == ST_IDLE);
  assign raw_hit    = cmp_valid && box_overlap(ram_q, cur) && tag_match(mask, ram_q.tag, cur.tag);
  assign take_hit   = raw_hit && (hit_cnt != IDX_W'(MAX_BOXES - 1));
  assign out_free   = !result_valid || result_ready;
  assign adv        = !(take_hit && pend_valid && !out_free);
  assign issue      = (state == ST_SCAN) && adv && (rd_idx < count);
  assign flush_go   = (state == ST_FLUSH) && (!pend_valid || out_free);
  assign not_full   = (count < CNT_W'(MAX_BOXES));
  assign emit       = pend_valid && (((state == ST_SCAN) && take_hit && adv) || flush_go);

  assign ram_rd.en   = issue;
  assign ram_rd.addr = rd_idx[IDX_W-1:0];
  assign ram_wr.en   = flush_go && not_full;
  assign ram_wr.addr = count[IDX_W-1:0];
  assign ram_wr.data = cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      rd_idx       <= '0;
      cmp_valid    <= 1'b0;
      hit_cnt      <= '0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (item_valid) begin
            cur.x     <= item.box_x;
            cur.y     <= item.box_y;
            cur.w     <= item.box_w;
            cur.h     <= item.box_h;
            cur.tag   <= item.box_tag;
            rd_idx    <= '0;
            cmp_valid <= 1'b0;
            hit_cnt   <= '0;
            if (item.frame_start) begin
              count <= '0;
            end
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (adv) begin
            cmp_valid <= issue;
            cmp_idx   <= rd_idx[IDX_W-1:0];
            if (issue) begin
              rd_idx <= rd_idx + 1'b1;
            end
            if (take_hit) begin
              hit_cnt    <= hit_cnt + 1'b1;
              pend_idx   <= cmp_idx;
              pend_valid <= 1'b1;
              if (pend_valid) begin
                result.earlier_index <= pend_idx;
                result.new_index     <= count;
                result.last_pair     <= 1'b0;
              end
            end
          end
          if (!cmp_valid && (rd_idx >= count)) begin
            state <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (flush_go) begin
            if (pend_valid) begin
              result.earlier_index <= pend_idx;
              result.new_index     <= count;
              result.last_pair     <= 1'b1;
            end
            pend_valid <= 1'b0;
            if (not_full) begin
              count <= count + 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/aabb_chk.sv
// ----------------------------------------------------------------------------
// aabb_chk
// Port-level checks of the collision scan, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module aabb_chk
  import aabb_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              item_valid,
  input wire logic              item_ready,
  input wire logic              result_valid,
  input wire logic              result_ready,
  input wire result_word_t      result
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result word changed or dropped while stalled");

  a_one_box_at_a_time: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("second word taken while a scan is running");

  a_index_order: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ({1'b0, result.earlier_index} < result.new_index))
    else $error("earlier slot not below the new slot");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule

bind aabb_pair_collision_scan aabb_chk u_chk (.*);

`default_nettype wire

FILE: test/tb_aabb_pair_collision_scan.sv
// ----------------------------------------------------------------------------
// tb_aabb_pair_collision_scan
// Self-checking bench for the pairwise box collision scan. Boxes are sent as
// frames, many of them clustered or crowded so that they overlap. A local
// scan of the stored boxes predicts every reported pair. Random gaps are
// inserted on both handshakes, except in one phase that runs without them. The
// subscription mask is rewritten between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_aabb_pair_collision_scan;
  import aabb_pkg::*;

  typedef enum int {CROWD, CLUSTER, WILD} frame_style_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [MASK_W-1:0] cfg_wdata = '0;
  logic              item_valid = 1'b0;
  logic              item_ready;
  item_word_t        item = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  result_word_t      result;

  item_word_t   pending_boxes[$];
  result_word_t expected_pairs[$];

  logic [MASK_W-1:0] mask_model = '0;
  int kept_x[MAX_BOXES];
  int kept_y[MAX_BOXES];
  int kept_w[MAX_BOXES];
  int kept_h[MAX_BOXES];
  logic [TAG_W-1:0] kept_tag[MAX_BOXES];
  int kept_count = 0;

  int  fail_count = 0;
  int  boxes_sent = 0;
  int  pairs_seen = 0;
  int  full_list_boxes = 0;
  int  most_pairs = 0;
  bit  no_idle = 1'b0;
  int  send_gap = 0;
  int  stall_left = 0;

  aabb_pair_collision_scan u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  function automatic item_word_t make_box(bit fs, int x, int y, int w, int h, int tag);
    item_word_t b;
    b.frame_start = fs;
    b.box_x = x[15:0];
    b.box_y = y[15:0];
    b.box_w = w[14:0];
    b.box_h = h[14:0];
    b.box_tag = tag[TAG_W-1:0];
    return b;
  endfunction

  function automatic item_word_t random_box(bit fs, frame_style_t style);
    int tag;
    tag = $urandom_range(7, 0);
    if (style == CLUSTER && $urandom_range(9, 0) == 0) style = WILD;
    case (style)
      CROWD: begin
        return make_box(fs, $urandom_range(40, 0) - 100, $urandom_range(40, 0) - 100,
                        $urandom_range(300, 150), $urandom_range(300, 150), tag);
      end
      CLUSTER: begin
        return make_box(fs, $urandom_range(128, 0) - 64, $urandom_range(128, 0) - 64,
                        $urandom_range(64, 0), $urandom_range(64, 0), tag);
      end
      default: begin
        return make_box(fs, $urandom_range(65535, 0), $urandom_range(65535, 0),
                        $urandom_range(32767, 0), $urandom_range(32767, 0), tag);
      end
    endcase
  endfunction

  function automatic void queue_box(item_word_t b);
    pending_boxes.insert(pending_boxes.size(), b);
  endfunction

  // Scan the stored boxes in slot order, the way the block does, and queue the pairs.
  task automatic predict_pairs(item_word_t b);
    int nx, ny, nw, nh, n, i;
    logic [CNT_W-1:0] slot;
    result_word_t found[$];
    result_word_t r;
    nx = b.box_x;
    ny = b.box_y;
    nw = b.box_w;
    nh = b.box_h;
    n = 0;
    if (b.frame_start) kept_count = 0;
    slot = CNT_W'((kept_count < MAX_BOXES) ? kept_count : MAX_BOXES);
    if (kept_count == MAX_BOXES) full_list_boxes++;
    for (i = 0; i < kept_count; i++) begin
      if (n >= MAX_BOXES - 1) break;
      if ((kept_y[i] + kept_h[i] > ny) && (kept_y[i] < ny + nh) &&
          (kept_x[i] + kept_w[i] > nx) && (kept_x[i] < nx + nw) &&
          (mask_model[{kept_tag[i], b.box_tag}] || mask_model[{b.box_tag, kept_tag[i]}]))
      begin
        r.earlier_index = i[IDX_W-1:0];
        r.new_index = slot;
        r.last_pair = 1'b0;
        found.insert(found.size(), r);
        n++;
      end
    end
    if (n > 0) found[n-1].last_pair = 1'b1;
    if (n > most_pairs) most_pairs = n;
    foreach (found[k]) expected_pairs.insert(expected_pairs.size(), found[k]);
    if (kept_count < MAX_BOXES) begin
      kept_x[kept_count] = nx;
      kept_y[kept_count] = ny;
      kept_w[kept_count] = nw;
      kept_h[kept_count] = nh;
      kept_tag[kept_count] = b.box_tag;
      kept_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (item_valid && item_ready) begin
        predict_pairs(item);
        boxes_sent++;
      end
      if (!item_valid || item_ready) begin
        if (send_gap > 0) begin
          item_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_boxes.size() > 0) begin
          item <= pending_boxes.pop_front();
          item_valid <= 1'b1;
          send_gap <= pick_gap();
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      result_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      result_ready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    result_word_t want;
    if (!rst && result_valid && result_ready) begin
      pairs_seen++;
      if (expected_pairs.size() == 0) begin
        $error("unexpected result word: earlier_index %0d new_index %0d last_pair %0d",
               result.earlier_index, result.new_index, result.last_pair);
        fail_count++;
      end else begin
        want = expected_pairs.pop_front();
        if (result.earlier_index !== want.earlier_index) begin
          $error("earlier_index: expected %0d, actual %0d", want.earlier_index,
                 result.earlier_index);
          fail_count++;
        end
        if (result.new_index !== want.new_index) begin
          $error("new_index: expected %0d, actual %0d", want.new_index, result.new_index);
          fail_count++;
        end
        if (result.last_pair !== want.last_pair) begin
          $error("last_pair: expected %0d, actual %0d", want.last_pair, result.last_pair);
          fail_count++;
        end
      end
    end
  end

  task automatic drain();
    @(negedge clk);
    while (pending_boxes.size() != 0 || item_valid || expected_pairs.size() != 0)
      @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_mask(logic [MASK_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    mask_model = value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic queue_frames(int total, bit crowd_first);
    int made, len, k;
    frame_style_t style;
    made = 0;
    while (made < total) begin
      if ((crowd_first && made == 0) || $urandom_range(7, 0) == 0) begin
        style = CROWD;
        len = $urandom_range(36, 33);
      end else begin
        style = CLUSTER;
        len = $urandom_range(20, 1);
      end
      for (k = 0; k < len; k++) begin
        queue_box(random_box(k == 0 || $urandom_range(29, 0) == 0, style));
        made++;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    write_mask('1);

    queue_box(make_box(1, -32768, -32768, 32767, 32767, 0));
    queue_box(make_box(0, 32767, 32767, 32767, 32767, 7));
    queue_box(make_box(0, -1, -1, 1, 1, 3));
    queue_box(make_box(0, -2, -2, 1, 1, 5));
    queue_box(make_box(0, 32767, -32768, 0, 0, 2));
    queue_box(make_box(1, 0, 0, 10, 10, 1));
    queue_box(make_box(0, 10, 0, 10, 10, 2));
    queue_box(make_box(0, 0, 10, 10, 10, 2));
    queue_box(make_box(0, -10, -10, 10, 10, 2));
    queue_box(make_box(0, 9, 9, 1, 1, 4));
    queue_box(make_box(0, 5, 5, 0, 0, 6));
    queue_box(make_box(0, 0, 0, 20, 20, 0));
    queue_box(make_box(0, -5, -5, 0, 0, 7));
    queue_box(make_box(0, -32768, 32767, 32767, 0, 5));
    queue_frames(85, 1);
    drain();

    write_mask('0);
    queue_frames(50, 0);
    drain();

    write_mask({$urandom, $urandom});
    queue_frames(50, 0);
    drain();
    queue_frames(50, 0);
    drain();

    no_idle = 1'b1;
    write_mask(64'h8040_2010_0804_0201);
    queue_frames(60, 0);
    drain();
    no_idle = 1'b0;

    write_mask(64'h8000_0000_0020_0001);
    queue_frames(70, 1);
    drain();

    $display("Sent %0d boxes under five subscription masks and checked %0d pairs.",
             boxes_sent, pairs_seen);
    $display("%0d boxes met a full list; the most pairs for one box was %0d.",
             full_list_boxes, most_pairs);
    if (fail_count == 0) begin
      $display("aabb_pair_collision_scan test passed");
    end else begin
      $display("aabb_pair_collision_scan test failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("aabb_pair_collision_scan test failed");
    $finish;
  end

endmodule
